>>> rtl/vcfgp_pkg.sv
// Shared types and constants for the VCF line genotype parser.
// Used by the front parser, the result queue, the back serialiser and the top level.
package vcfgp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_ONE   = 8'd49;
  localparam logic [7:0] CHAR_DOT   = 8'd46;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam logic [3:0] FIELD_CHROM  = 4'd0;
  localparam logic [3:0] FIELD_POS    = 4'd1;
  localparam logic [3:0] FIELD_ALT    = 4'd4;
  localparam logic [3:0] FIELD_FORMAT = 4'd8;
  localparam logic [3:0] FIELD_SAMPLE = 4'd9;

  localparam logic CFG_SAMPLE_COUNT = 1'b0;
  localparam logic CFG_SITE_LIMIT   = 1'b1;

  localparam logic [1:0] GT_MISSING = 2'd3;
  localparam logic [30:0] SAT31 = 31'h7FFFFFFF;

  typedef enum logic [1:0] {
    KIND_SITE      = 2'd0,
    KIND_GENOTYPE  = 2'd1,
    KIND_LINE_DONE = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_DOT   = 2'd2
  } cls_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] sample_number;
    logic [1:0]  genotype_code;
    logic [15:0] samples_missing;
    logic [3:0]  failed_field;
  } result_t;

  typedef struct packed {
    logic [23:0] site_number;
    logic [30:0] chromosome;
    logic [30:0] position;
    result_t     first;
    result_t     second;
    logic        two;
  } pair_t;

endpackage

>>> rtl/vcf_line_genotype_parser.sv
// Top level of the VCF line genotype parser: front parser, result queue, back serialiser.
// Depends on vcfgp_pkg, vcfgp_front, vcfgp_queue and vcfgp_back.
//
// Usage: bytes of VCF data lines enter on text_byte with end_of_line marking the last
// byte of each line; a byte transfers on a rising edge with push high and full low.
// Results leave in order: while empty is low the oldest result is on the result ports,
// and it transfers on a rising edge with pop high. last_result marks the final result
// caused by one byte. sample_count and site_limit are written through cfg_write,
// cfg_index and cfg_data while the block is idle.
// Throughput is one byte per cycle while full is low; the output register delivers one result
// per cycle while pop is high, so a byte that closes a field and its line with two results
// takes an extra output slot, absorbed by the four-pair queue until full rises.
// A result passes through the queue and then the output register before it reaches the ports,
// where it transfers on a rising edge with pop high.
// When pop is held low the queue fills and full stops further bytes; nothing is lost.
// Reset (rst, synchronous) clears the line state, the kept-site count, the queue and the
// output register, and restores sample_count to 0 and site_limit to its maximum.
module vcf_line_genotype_parser #(
  parameter int MAX_SAMPLES = 65535,
  parameter int MAX_SITES   = 16777215
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_line,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [23:0] site_number,
  output logic [30:0] chromosome,
  output logic [30:0] position,
  output logic [15:0] sample_number,
  output logic [1:0]  genotype_code,
  output logic [15:0] samples_missing,
  output logic [3:0]  failed_field,
  output logic        last_result
);
  import vcfgp_pkg::*;

  pair_t push_data, pop_data;
  logic  accept, q_push, q_pop, q_empty;

  assign accept = push && !full;

  vcfgp_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .MAX_SITES  (MAX_SITES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .text_byte  (text_byte),
    .end_of_line(end_of_line),
    .accept     (accept),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  vcfgp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(push_data),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(pop_data),
    .empty  (q_empty)
  );

  vcfgp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .kind           (kind),
    .site_number    (site_number),
    .chromosome     (chromosome),
    .position       (position),
    .sample_number  (sample_number),
    .genotype_code  (genotype_code),
    .samples_missing(samples_missing),
    .failed_field   (failed_field),
    .last_result    (last_result)
  );

endmodule

>>> rtl/vcfgp_front.sv
// Front parser: holds the configuration registers and the per-line state, takes one byte
// per transfer and forms the results, at most two, that it causes. Depends on vcfgp_pkg.
module vcfgp_front #(
  parameter int MAX_SAMPLES = 65535,
  parameter int MAX_SITES   = 16777215
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [23:0]      cfg_data,
  input  logic [7:0]       text_byte,
  input  logic             end_of_line,
  input  logic             accept,
  output logic             q_push,
  output vcfgp_pkg::pair_t q_data
);
  import vcfgp_pkg::*;

  localparam logic [15:0] SampleCap = (MAX_SAMPLES > 65535) ? 16'hFFFF : 16'(MAX_SAMPLES);
  localparam logic [23:0] SiteCap = (MAX_SITES > 16777215) ? 24'hFFFFFF : 24'(MAX_SITES);

  logic [15:0] sample_count;
  logic [23:0] site_limit;

  logic [3:0]  field_index, field_index_next;
  logic [2:0]  token_length, token_length_next;
  cls_t        first_char_class, first_char_class_next;
  cls_t        third_char_class, third_char_class_next;
  logic [30:0] chrom_value, chrom_value_next;
  logic [30:0] pos_value, pos_value_next;
  logic        digits_done, digits_done_next;
  logic        comma_seen, comma_seen_next;
  logic        drop_line, drop_line_next;
  logic [15:0] sample_counter, sample_counter_next;
  logic [23:0] sites_kept, sites_kept_next;

  logic [15:0] count;
  logic [23:0] limit;
  logic        drop_eff, is_tab, is_digit;
  cls_t        cls;
  logic        r0_valid, r1_valid;
  result_t     r0, r1;
  logic [23:0] site;

  function automatic logic [30:0] add_digit(input logic [30:0] v, input logic [3:0] d);
    logic [34:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {31'd0, d};
    return (t > {4'd0, SAT31}) ? SAT31 : t[30:0];
  endfunction

  function automatic logic [1:0] decode_gt(input logic [2:0] len, input cls_t f, input cls_t t);
    logic [1:0] g;
    g = 2'd0;
    if (len == 3'd1) begin
      g = (f == CLS_ONE) ? 2'd1 : ((f == CLS_DOT) ? GT_MISSING : 2'd0);
    end else if (len != 3'd3) begin
      g = GT_MISSING;
    end else if (f == CLS_DOT || t == CLS_DOT) begin
      g = GT_MISSING;
    end else begin
      g = {1'b0, f == CLS_ONE} + {1'b0, t == CLS_ONE};
    end
    return g;
  endfunction

  assign count = (sample_count < SampleCap) ? sample_count : SampleCap;
  assign limit = (site_limit < SiteCap) ? site_limit : SiteCap;

  always_comb begin
    field_index_next      = field_index;
    token_length_next     = token_length;
    first_char_class_next = first_char_class;
    third_char_class_next = third_char_class;
    chrom_value_next      = chrom_value;
    pos_value_next        = pos_value;
    digits_done_next      = digits_done;
    comma_seen_next       = comma_seen;
    sample_counter_next   = sample_counter;
    sites_kept_next       = sites_kept;
    r0_valid = 1'b0;
    r1_valid = 1'b0;
    r0 = '0;
    r1 = '0;
    drop_eff = drop_line || (field_index <= FIELD_ALT && sites_kept >= limit);
    drop_line_next = drop_eff;
    is_tab = (text_byte == CHAR_TAB);
    is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    cls = (text_byte == CHAR_ONE) ? CLS_ONE : ((text_byte == CHAR_DOT) ? CLS_DOT : CLS_OTHER);
    if (!drop_eff) begin
      if (!is_tab) begin
        if (token_length == 3'd0) first_char_class_next = cls;
        if (token_length == 3'd2) third_char_class_next = cls;
        if ((field_index == FIELD_CHROM || field_index == FIELD_POS) && !digits_done) begin
          if (!is_digit) begin
            digits_done_next = 1'b1;
          end else if (field_index == FIELD_CHROM) begin
            chrom_value_next = add_digit(chrom_value, text_byte[3:0]);
          end else begin
            pos_value_next = add_digit(pos_value, text_byte[3:0]);
          end
        end
        if (field_index == FIELD_ALT && text_byte == CHAR_COMMA) comma_seen_next = 1'b1;
        if (token_length != 3'd7) token_length_next = token_length + 3'd1;
      end
      if (is_tab || end_of_line) begin
        if (token_length_next == 3'd0 && field_index <= FIELD_FORMAT) begin
          r0_valid = 1'b1;
          r0.kind = KIND_ERROR;
          r0.failed_field = field_index;
          drop_line_next = 1'b1;
        end else if (field_index == FIELD_ALT) begin
          if (comma_seen_next) begin
            drop_line_next = 1'b1;
          end else begin
            r0_valid = 1'b1;
            r0.kind = KIND_SITE;
            sites_kept_next = sites_kept + 24'd1;
          end
        end else if (field_index == FIELD_SAMPLE && sample_counter < count) begin
          r0_valid = 1'b1;
          r0.kind = KIND_GENOTYPE;
          r0.sample_number = sample_counter;
          r0.genotype_code = decode_gt(token_length_next, first_char_class_next,
                                       third_char_class_next);
          sample_counter_next = sample_counter + 16'd1;
        end
        if (!drop_line_next) begin
          if (field_index < FIELD_SAMPLE) field_index_next = field_index + 4'd1;
          token_length_next     = 3'd0;
          first_char_class_next = CLS_OTHER;
          third_char_class_next = CLS_OTHER;
          digits_done_next      = 1'b0;
        end
      end
      if (end_of_line && !drop_line_next) begin
        r1_valid = 1'b1;
        if (field_index_next < FIELD_SAMPLE) begin
          r1.kind = KIND_ERROR;
          r1.failed_field = field_index_next;
        end else begin
          r1.kind = KIND_LINE_DONE;
          r1.samples_missing = count - sample_counter_next;
        end
      end
    end
  end

  // Every result of one byte carries the same site number, taken after the byte's update.
  assign site = (field_index_next >= FIELD_ALT + 4'd1 && sites_kept_next != 24'd0) ?
                sites_kept_next - 24'd1 : sites_kept_next;

  always_comb begin
    q_data.site_number = site;
    q_data.chromosome  = chrom_value_next;
    q_data.position    = pos_value_next;
    q_data.first       = r0_valid ? r0 : r1;
    q_data.second      = r1;
    q_data.two         = r0_valid && r1_valid;
  end

  assign q_push = accept && (r0_valid || r1_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= 16'd0;
      site_limit   <= 24'hFFFFFF;
    end else if (cfg_write) begin
      if (cfg_index == CFG_SAMPLE_COUNT) sample_count <= cfg_data[15:0];
      if (cfg_index == CFG_SITE_LIMIT) site_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index      <= 4'd0;
      token_length     <= 3'd0;
      first_char_class <= CLS_OTHER;
      third_char_class <= CLS_OTHER;
      chrom_value      <= 31'd0;
      pos_value        <= 31'd0;
      digits_done      <= 1'b0;
      comma_seen       <= 1'b0;
      drop_line        <= 1'b0;
      sample_counter   <= 16'd0;
      sites_kept       <= 24'd0;
    end else if (accept) begin
      sites_kept <= sites_kept_next;
      if (end_of_line) begin
        field_index      <= 4'd0;
        token_length     <= 3'd0;
        first_char_class <= CLS_OTHER;
        third_char_class <= CLS_OTHER;
        chrom_value      <= 31'd0;
        pos_value        <= 31'd0;
        digits_done      <= 1'b0;
        comma_seen       <= 1'b0;
        drop_line        <= 1'b0;
        sample_counter   <= 16'd0;
      end else begin
        field_index      <= field_index_next;
        token_length     <= token_length_next;
        first_char_class <= first_char_class_next;
        third_char_class <= third_char_class_next;
        chrom_value      <= chrom_value_next;
        pos_value        <= pos_value_next;
        digits_done      <= digits_done_next;
        comma_seen       <= comma_seen_next;
        drop_line        <= drop_line_next;
        sample_counter   <= sample_counter_next;
      end
    end
  end

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_line |=> field_index == FIELD_CHROM && !drop_line)
    else $error("line state not cleared after the last byte of a line");
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    field_index <= FIELD_SAMPLE)
    else $error("field index beyond the sample columns");
  a_kept_limit: assert property (@(posedge clk) disable iff (rst)
    accept && sites_kept_next != sites_kept |-> sites_kept < limit)
    else $error("site kept beyond the site limit");

endmodule

>>> rtl/vcfgp_queue.sv
// Short queue of result pairs between the front parser and the back serialiser.
// Depends on vcfgp_pkg for the pair type and the queue depth.
module vcfgp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  vcfgp_pkg::pair_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output vcfgp_pkg::pair_t rd_data,
  output logic             empty
);
  import vcfgp_pkg::*;

  localparam logic [QPTR_W-1:0] LastSlot = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] DepthCount = QCNT_W'(QUEUE_DEPTH);

  pair_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_wr, do_rd;

  assign full    = (fill == DepthCount);
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DepthCount)
    else $error("queue fill beyond its depth");
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> fill == $past(fill) + 1'b1)
    else $error("queue fill not raised by a write");
  a_fill_down: assert property (@(posedge clk) disable iff (rst)
    do_rd && !do_wr |=> fill == $past(fill) - 1'b1)
    else $error("queue fill not lowered by a read");

endmodule

>>> rtl/vcfgp_back.sv
// Back serialiser: takes result pairs from the queue into an output register and
// presents them one result per transfer. Depends on vcfgp_pkg.
module vcfgp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  vcfgp_pkg::pair_t q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       kind,
  output logic [23:0]      site_number,
  output logic [30:0]      chromosome,
  output logic [30:0]      position,
  output logic [15:0]      sample_number,
  output logic [1:0]       genotype_code,
  output logic [15:0]      samples_missing,
  output logic [3:0]       failed_field,
  output logic             last_result
);
  import vcfgp_pkg::*;

  pair_t   cur;
  result_t res;
  logic    hold_valid, phase;
  logic    take, done, advance, refill;

  assign done    = phase || !cur.two;
  assign take    = hold_valid && pop;
  assign advance = take && !done;
  assign refill  = !hold_valid || (take && done);
  assign q_pop   = refill && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (advance) begin
      phase <= 1'b1;
    end else if (refill) begin
      phase      <= 1'b0;
      hold_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  assign res             = phase ? cur.second : cur.first;
  assign empty           = !hold_valid;
  assign kind            = res.kind;
  assign site_number     = cur.site_number;
  assign chromosome      = cur.chromosome;
  assign position        = cur.position;
  assign sample_number   = res.sample_number;
  assign genotype_code   = res.genotype_code;
  assign samples_missing = res.samples_missing;
  assign failed_field    = res.failed_field;
  assign last_result     = done;

  a_phase_pair: assert property (@(posedge clk) disable iff (rst)
    phase |-> hold_valid && cur.two)
    else $error("second result shown without a pair of two");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> phase && hold_valid)
    else $error("second result of a pair not shown after the first");
  a_refill: assert property (@(posedge clk) disable iff (rst)
    take && done && q_empty |=> empty)
    else $error("result shown with nothing left to show");

endmodule
